### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be seen out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### sv/ptem_pkg.sv
package ptem_pkg;

    // Number of tracks with a stored expression value.
    localparam int TRACK_COUNT = 8;
    localparam int TRK_IW      = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

    // Field widths
    localparam int TRACK_W = 3;
    localparam int PRES_W  = 16;
    localparam int CHAN_W  = 4;
    localparam int VAL_W   = 7;
    localparam int DIR_W   = 2;
    localparam int CC_W    = 7;
    localparam int CURVE_W = 2;
    localparam int PCT_W   = 7;
    localparam int BIT_W   = 3;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_CURVE  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MIN    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MAX    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SMOOTH = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_EXPR   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_BREATH = 3'd5;

    localparam logic [CURVE_W-1:0] CURVE_LINEAR = 2'd0;
    localparam logic [CURVE_W-1:0] CURVE_SQUARE = 2'd1;
    localparam logic [CURVE_W-1:0] CURVE_SQRT   = 2'd2;
    localparam logic [CURVE_W-1:0] CURVE_SCURVE = 2'd3;

    localparam logic [DIR_W-1:0] DIR_NEUTRAL = 2'd0;
    localparam logic [DIR_W-1:0] DIR_PUSH    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_PULL    = 2'd2;

    // Top bit of a 7-bit quotient or root, first step of both iterations.
    localparam logic [BIT_W-1:0] Q_MSB = 3'd6;

    typedef struct packed {
        logic [CURVE_W-1:0]       curve_select;
        logic signed [PRES_W-1:0] min_pressure;
        logic signed [PRES_W-1:0] max_pressure;
        logic [PCT_W-1:0]         smoothing_percent;
        logic [CC_W-1:0]          expression_controller;
        logic [CC_W-1:0]          breath_controller;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        curve_select:          CURVE_LINEAR,
        min_pressure:          -16'sd500,
        max_pressure:          16'sd500,
        smoothing_percent:     7'd30,
        expression_controller: 7'd11,
        breath_controller:     7'd2
    };

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             range;
        logic             prep;
        logic             div_step;
        logic             clamp;
        logic             shape1;
        logic             sqrt_step;
        logic             shape2;
        logic             mix;
        logic             scale;
        logic             finish;
        logic [BIT_W-1:0] bit_idx;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_sqrt;
    } dp_stat_t;

endpackage

### sv/ptem_dpath.sv
module ptem_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ptem_pkg::cfg_t                     cfg,
    input  ptem_pkg::dp_cmd_t                  cmd,
    output ptem_pkg::dp_stat_t                 stat,
    input  logic [ptem_pkg::TRACK_W-1:0]       s_track,
    input  logic signed [ptem_pkg::PRES_W-1:0] s_pressure,
    input  logic [ptem_pkg::CHAN_W-1:0]        s_channel,
    output logic [ptem_pkg::TRACK_W-1:0]       m_out_track,
    output logic [ptem_pkg::CHAN_W-1:0]        m_out_channel,
    output logic [ptem_pkg::VAL_W-1:0]         m_expression_value,
    output logic [ptem_pkg::DIR_W-1:0]         m_direction,
    output logic                               m_send,
    output logic [ptem_pkg::CC_W-1:0]          m_expression_number,
    output logic [ptem_pkg::CC_W-1:0]          m_breath_number
);
    import ptem_pkg::*;

    // Three-segment S curve on 0..127.
    function automatic logic [VAL_W-1:0] s_curve(input logic [VAL_W-1:0] x);
        logic [7:0] mid;
        logic [7:0] res;
        mid = ({1'b0, x} - 8'd32) * 8'd3;
        if (x < 7'd32) begin
            res = {2'b00, x[6:1]};
        end else if (x < 7'd96) begin
            res = 8'd16 + {1'b0, mid[7:1]};
        end else begin
            res = 8'd112 + {3'b000, 5'(x - 7'd96) >> 1};
        end
        return res[VAL_W-1:0];
    endfunction

    // Item fields
    logic [TRACK_W-1:0]       trk_reg, trk_next;
    logic [CHAN_W-1:0]        chan_reg, chan_next;
    logic signed [PRES_W-1:0] p_reg, p_next;
    logic [DIR_W-1:0]         dir_reg, dir_next;

    // Scaling and division
    logic signed [23:0] num_reg, num_next;
    logic signed [16:0] den_reg, den_next;
    logic [22:0]        rem_reg, rem_next;
    logic [15:0]        dmag_reg, dmag_next;
    logic [VAL_W-1:0]   quot_reg, quot_next;
    logic               zero_reg, zero_next;
    logic               ovf_reg, ovf_next;

    // Curve and smoothing
    logic [VAL_W-1:0] x_reg, x_next;
    logic [13:0]      prod_reg, prod_next;
    logic [13:0]      n_reg, n_next;
    logic [VAL_W-1:0] root_reg, root_next;
    logic [VAL_W-1:0] y_reg, y_next;
    logic [13:0]      sum_reg, sum_next;
    logic [VAL_W-1:0] qe_reg, qe_next;

    logic [VAL_W-1:0] cur_reg [TRACK_COUNT];

    // Result register
    logic [TRACK_W-1:0] o_trk_reg;
    logic [CHAN_W-1:0]  o_chan_reg;
    logic [VAL_W-1:0]   o_val_reg;
    logic [DIR_W-1:0]   o_dir_reg;
    logic               o_send_reg;
    logic [CC_W-1:0]    o_expr_reg;
    logic [CC_W-1:0]    o_breath_reg;

    logic signed [16:0] diff;
    logic signed [16:0] range_raw;
    logic signed [23:0] diff_x;
    logic signed [23:0] num_abs;
    logic signed [16:0] den_abs;
    logic [22:0]        nmag;
    logic [15:0]        dmag;
    logic [22:0]        den_sh;
    logic [VAL_W-1:0]   trial;
    logic [13:0]        trial_sq;
    logic [VAL_W-1:0]   sq_qe;
    logic [13:0]        sq_rem;
    logic [VAL_W-1:0]   sq_y;
    logic [PCT_W-1:0]   s_eff;
    logic [PCT_W-1:0]   wt;
    logic               track_ok;
    logic [TRK_IW-1:0]  idx;
    logic [VAL_W-1:0]   old_val;
    logic [21:0]        scaled;
    logic [13:0]        r100;
    logic [VAL_W-1:0]   dv;
    logic [VAL_W-1:0]   value;
    logic               send;

    assign stat.is_sqrt = (cfg.curve_select == CURVE_SQRT);

    assign track_ok = (32'(trk_reg) < TRACK_COUNT);
    assign idx      = TRK_IW'(trk_reg);
    assign old_val  = track_ok ? cur_reg[idx] : '0;
    assign s_eff    = (cfg.smoothing_percent > 7'd100) ? 7'd100 : cfg.smoothing_percent;
    assign wt       = 7'd100 - s_eff;

    always_comb begin
        diff      = $signed({p_reg[PRES_W-1], p_reg})
                  - $signed({cfg.min_pressure[PRES_W-1], cfg.min_pressure});
        range_raw = $signed({cfg.max_pressure[PRES_W-1], cfg.max_pressure})
                  - $signed({cfg.min_pressure[PRES_W-1], cfg.min_pressure});
        diff_x    = $signed({{7{diff[16]}}, diff});

        num_abs = num_reg[23] ? -num_reg : num_reg;
        den_abs = den_reg[16] ? -den_reg : den_reg;
        nmag    = num_abs[22:0];
        dmag    = den_abs[15:0];

        den_sh   = {7'd0, dmag_reg} << cmd.bit_idx;
        trial    = root_reg | (7'd1 << cmd.bit_idx);
        trial_sq = {7'd0, trial} * {7'd0, trial};

        // x*x/127: the shift estimate is low by at most one
        sq_qe  = prod_reg[13:7];
        sq_rem = prod_reg - ({sq_qe, 7'd0} - {7'd0, sq_qe});
        sq_y   = sq_qe + 7'(sq_rem >= 14'd127);

        // sum/100 via 163/2^14, low by at most one
        scaled = {8'd0, sum_reg} * 22'd163;
        r100   = sum_reg - {7'd0, qe_reg} * 14'd100;
        dv     = qe_reg + 7'(r100 >= 14'd100);

        value = (s_eff == '0) ? y_reg : dv;
        if (!track_ok) begin
            value = '0;
        end
        send = track_ok && (value != old_val);
    end

    always_comb begin
        trk_next  = trk_reg;
        chan_next = chan_reg;
        p_next    = p_reg;
        dir_next  = dir_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        quot_next = quot_reg;
        zero_next = zero_reg;
        ovf_next  = ovf_reg;
        x_next    = x_reg;
        prod_next = prod_reg;
        n_next    = n_reg;
        root_next = root_reg;
        y_next    = y_reg;
        sum_next  = sum_reg;
        qe_next   = qe_reg;

        if (cmd.load) begin
            trk_next  = s_track;
            chan_next = s_channel;
            p_next    = s_pressure;
            if (s_pressure > 16'sd10) begin
                dir_next = DIR_PUSH;
            end else if (s_pressure < -16'sd10) begin
                dir_next = DIR_PULL;
            end else begin
                dir_next = DIR_NEUTRAL;
            end
        end
        if (cmd.range) begin
            num_next = (diff_x <<< 7) - diff_x;
            den_next = (range_raw == 17'sd0) ? 17'sd1 : range_raw;
        end
        if (cmd.prep) begin
            rem_next  = nmag;
            dmag_next = dmag;
            quot_next = '0;
            // opposite signs give a quotient at or below zero
            zero_next = num_reg[23] ^ den_reg[16];
            ovf_next  = (nmag >= {dmag, 7'd0});
        end
        if (cmd.div_step && (rem_reg >= den_sh)) begin
            rem_next           = rem_reg - den_sh;
            quot_next[cmd.bit_idx] = 1'b1;
        end
        if (cmd.clamp) begin
            x_next = zero_reg ? '0 : (ovf_reg ? 7'd127 : quot_reg);
        end
        if (cmd.shape1) begin
            prod_next = {7'd0, x_reg} * {7'd0, x_reg};
            n_next    = {x_reg, 7'd0} - {7'd0, x_reg};
            root_next = '0;
        end
        if (cmd.sqrt_step && (trial_sq <= n_reg)) begin
            root_next = trial;
        end
        if (cmd.shape2) begin
            case (cfg.curve_select)
                CURVE_SQUARE: y_next = sq_y;
                CURVE_SQRT:   y_next = root_reg;
                CURVE_SCURVE: y_next = s_curve(x_reg);
                default:      y_next = x_reg;
            endcase
        end
        if (cmd.mix) begin
            sum_next = {7'd0, old_val} * {7'd0, s_eff} + {7'd0, y_reg} * {7'd0, wt};
        end
        if (cmd.scale) begin
            qe_next = scaled[20:14];
        end
    end

    always_ff @(posedge aclk) begin
        trk_reg  <= trk_next;
        chan_reg <= chan_next;
        p_reg    <= p_next;
        dir_reg  <= dir_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        quot_reg <= quot_next;
        zero_reg <= zero_next;
        ovf_reg  <= ovf_next;
        x_reg    <= x_next;
        prod_reg <= prod_next;
        n_reg    <= n_next;
        root_reg <= root_next;
        y_reg    <= y_next;
        sum_reg  <= sum_next;
        qe_reg   <= qe_next;
        if (cmd.finish) begin
            o_trk_reg    <= trk_reg;
            o_chan_reg   <= chan_reg;
            o_val_reg    <= value;
            o_dir_reg    <= dir_reg;
            o_send_reg   <= send;
            o_expr_reg   <= cfg.expression_controller;
            o_breath_reg <= cfg.breath_controller;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TRACK_COUNT; i++) begin
                cur_reg[i] <= '0;
            end
        end else if (cmd.finish && send) begin
            cur_reg[idx] <= value;
        end
    end

    assign m_out_track         = o_trk_reg;
    assign m_out_channel       = o_chan_reg;
    assign m_expression_value  = o_val_reg;
    assign m_direction         = o_dir_reg;
    assign m_send              = o_send_reg;
    assign m_expression_number = o_expr_reg;
    assign m_breath_number     = o_breath_reg;

endmodule

### sv/ptem_ctrl.sv
`include "assert_macros.svh"

module ptem_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  ptem_pkg::dp_stat_t  stat,
    output ptem_pkg::dp_cmd_t   cmd
);
    import ptem_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RANGE  = 4'd1;
    localparam logic [3:0] ST_PREP   = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_CLAMP  = 4'd4;
    localparam logic [3:0] ST_SHAPE1 = 4'd5;
    localparam logic [3:0] ST_SQRT   = 4'd6;
    localparam logic [3:0] ST_SHAPE2 = 4'd7;
    localparam logic [3:0] ST_MIX    = 4'd8;
    localparam logic [3:0] ST_SCALE  = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next  = state_reg;
        bit_next    = bit_reg;
        cmd         = '0;
        cmd.bit_idx = bit_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                cmd.range  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                bit_next   = Q_MSB;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg - 3'd1;
                if (bit_reg == '0) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_SHAPE1;
            end
            ST_SHAPE1: begin
                cmd.shape1 = 1'b1;
                if (stat.is_sqrt) begin
                    bit_next   = Q_MSB;
                    state_next = ST_SQRT;
                end else begin
                    state_next = ST_SHAPE2;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                bit_next      = bit_reg - 3'd1;
                if (bit_reg == '0) begin
                    state_next = ST_SHAPE2;
                end
            end
            ST_SHAPE2: begin
                cmd.shape2 = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait here only while the previous item is still unread
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = cmd.finish ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_PROP(a_finish_room, aclk, aresetn, cmd.finish |-> (!m_valid_reg || m_ready), "result overwritten before taken")
    `ASSERT_PROP(a_accept_start, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_RANGE), "accepted item did not start")
    `ASSERT_PROP(a_valid_src, aclk, aresetn, $rose(m_valid_reg) |-> $past(cmd.finish), "result valid without finish")
    `ASSERT_NEVER(a_bit_range, aclk, aresetn, (state_reg == ST_DIV || state_reg == ST_SQRT) && (bit_reg > Q_MSB), "step index out of range")

endmodule

### sv/pressure_to_expression_mapper.sv
// Maps a signed pressure sample of one track to a 0..127 MIDI expression
// value: linear scaling between min_pressure and max_pressure (truncating
// signed division, clamped), one of four curves, then a percent moving
// average against the track's stored value. One item is in work at a time.
// The scaling uses a shift-subtract division of 7 quotient steps, and the
// square root curve adds a bit-by-bit root of 7 more steps; each other
// step of the controller is a single state. A finished item sits in the
// output register, so the next item is accepted while it waits to be
// taken; that next item then holds in its last step until the output
// register is free. Configuration writes are meant for idle periods only.
module pressure_to_expression_mapper (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ptem_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [ptem_pkg::CFG_DW-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ptem_pkg::TRACK_W-1:0]       s_track,
    input  logic signed [ptem_pkg::PRES_W-1:0] s_pressure,
    input  logic [ptem_pkg::CHAN_W-1:0]        s_channel,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ptem_pkg::TRACK_W-1:0]       m_out_track,
    output logic [ptem_pkg::CHAN_W-1:0]        m_out_channel,
    output logic [ptem_pkg::VAL_W-1:0]         m_expression_value,
    output logic [ptem_pkg::DIR_W-1:0]         m_direction,
    output logic                               m_send,
    output logic [ptem_pkg::CC_W-1:0]          m_expression_number,
    output logic [ptem_pkg::CC_W-1:0]          m_breath_number
);
    import ptem_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CURVE:  cfg_next.curve_select          = cfg_wdata[CURVE_W-1:0];
                CFG_MIN:    cfg_next.min_pressure          = $signed(cfg_wdata);
                CFG_MAX:    cfg_next.max_pressure          = $signed(cfg_wdata);
                CFG_SMOOTH: cfg_next.smoothing_percent     = cfg_wdata[PCT_W-1:0];
                CFG_EXPR:   cfg_next.expression_controller = cfg_wdata[CC_W-1:0];
                CFG_BREATH: cfg_next.breath_controller     = cfg_wdata[CC_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ptem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptem_dpath u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .cmd                 (cmd),
        .stat                (stat),
        .s_track             (s_track),
        .s_pressure          (s_pressure),
        .s_channel           (s_channel),
        .m_out_track         (m_out_track),
        .m_out_channel       (m_out_channel),
        .m_expression_value  (m_expression_value),
        .m_direction         (m_direction),
        .m_send              (m_send),
        .m_expression_number (m_expression_number),
        .m_breath_number     (m_breath_number)
    );

endmodule
